@@ rtl/core/rpsb_pkg.sv @@
package rpsb_pkg;

	// item codes on the action field
	localparam int ACT_W = 2;
	localparam logic [ACT_W-1:0] ACT_BYTE    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_TICK    = 2'd1;
	localparam logic [ACT_W-1:0] ACT_SERVICE = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CEILING = 2'd2;

	localparam int BYTE_W = 8;
	localparam int CH_W   = 11;

	// packet side
	localparam int RADIO_CHANNELS = 12;
	localparam int PKT_BYTES      = 17;
	localparam int PKT_IDX_W      = 5;
	localparam int PKT_RD_BYTES   = (CH_W * RADIO_CHANNELS + BYTE_W - 1) / BYTE_W;

	// SBUS side
	localparam int SBUS_CH = 16;
	localparam int CHI_W   = 4;
	localparam logic [CHI_W-1:0] CARRIER_CH = 4'd12;
	localparam int FIRST_DATA_IDX = 1;
	localparam int DATA_LAST_IDX  = 22;
	localparam int FLAG_IDX       = 23;
	localparam int LAST_IDX       = 24;
	localparam logic [BYTE_W-1:0] FRAME_HDR     = 8'h0F;
	localparam logic [BYTE_W-1:0] FRAME_FTR     = 8'h00;
	localparam logic [BYTE_W-1:0] FLAG_FAILSAFE = 8'h08;
	localparam logic [BYTE_W-1:0] FLAG_NONE     = 8'h00;

	// resets
	localparam logic [CH_W-1:0] MS_MAX        = 11'h7FF;
	localparam logic [CH_W-1:0] CH_RESET      = 11'd172;
	localparam logic [CH_W-1:0] TIMEOUT_RESET = 11'd500;
	localparam logic [CH_W-1:0] FLOOR_RESET   = 11'd172;
	localparam logic [CH_W-1:0] CEIL_RESET    = 11'd1811;

	// channel mapping: (v - 1000) * 1639 / 1000 + 172
	localparam int MAP_OFFSET = 1000;
	localparam int MAP_GAIN   = 1639;
	localparam int MAP_DIV    = 1000;
	localparam int MAP_BASE   = 172;
	localparam int MAP_SHIFT  = 30;
	localparam int MAP_RECIP  = (1 << MAP_SHIFT) / MAP_DIV;
	localparam int PROD_W     = 22;
	localparam int MAG_W      = 21;

endpackage

@@ rtl/core/radio_packet_to_sbus_bridge.sv @@
// Radio packet to SBUS bridge.
//
// Input channel (in_valid / in_stall): each item is a packet byte, a 1 ms tick
// or a service pass, chosen by action. Bytes and ticks give no output. A
// service pass either does nothing visible, or emits one 25-byte SBUS frame on
// the output channel (out_valid / out_stall), header first, frame_last high on
// the footer byte.
// A service pass with a fresh packet runs the carrier step, then unpack and
// map, then frame serialization; a failsafe frame goes straight to frame
// serialization. The pace is set by the single read port of the packet buffer
// (one byte per cycle during unpack) and of the channel memory (one channel per
// load during emission).
// in_stall stays high from the accepted service pass until the frame is fully
// handed to the output register; only one item is worked at a time.
// When the receiver stalls, the output register holds its byte and frame
// serialization pauses; nothing is lost.
// Reset (arst_n low) clears control state, restores the config registers to
// their defaults and marks every channel invalid, so channels read as 172
// until written. The packet buffer is not cleared.
module radio_packet_to_sbus_bridge (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rpsb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rpsb_pkg::CH_W-1:0]      cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [rpsb_pkg::ACT_W-1:0]     action,
	input  logic [rpsb_pkg::BYTE_W-1:0]    data_byte,
	input  logic                          last_byte,
	input  logic                          carrier_detected,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [rpsb_pkg::BYTE_W-1:0]    frame_byte,
	output logic                          frame_last
);
	import rpsb_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_C12, S_UNPACK, S_EMIT} state_t;

	state_t state_q;

	// config
	logic [CH_W-1:0] timeout_q, floor_q, ceil_q;

	// control state
	logic [PKT_IDX_W-1:0] widx_q;
	logic                 pend_q;
	logic [CH_W-1:0]      ms_q;
	logic                 failsafe_q;
	logic                 carrier_q;

	// memories
	logic [BYTE_W-1:0] pkt_mem [PKT_BYTES];
	logic [CH_W-1:0]   chan_mem [SBUS_CH];
	logic [SBUS_CH-1:0] chan_vld_q;
	logic [CH_W-1:0]   ch_rd_q;
	logic              ch_ok_q;
	logic [BYTE_W-1:0] buf_rd_s1;

	// unpack
	logic [PKT_IDX_W-1:0] byte_ptr_q;
	logic                 byte_vld_s1;
	logic [17:0]          uacc_q;
	logic [4:0]           ucnt_q;
	logic [CHI_W-1:0]     uidx_q;

	// map pipeline
	logic                    vld_s2, vld_s3, vld_s4;
	logic [CH_W-1:0]         val_s2;
	logic [CHI_W-1:0]        idx_s2, idx_s3, idx_s4;
	logic signed [PROD_W-1:0] p_s3;
	logic [MAG_W-1:0]        mag_s4;
	logic [CH_W-1:0]         q0_s4;
	logic                    neg_s4;

	// emission
	logic [4:0]  ebyte_q;
	logic [4:0]  ch_ptr_q;
	logic [17:0] eacc_q;
	logic [4:0]  ecnt_q;

	// output register
	logic              out_valid_q;
	logic [BYTE_W-1:0] frame_byte_q;
	logic              frame_last_q;

	// ---------------------------------------------------------------
	// handshake
	logic in_acc, out_free;
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	logic svc_fail;
	assign svc_fail = ms_q > timeout_q;

	// ---------------------------------------------------------------
	// channel memory read side: entries never written read as 172
	logic [CHI_W-1:0] ch_rd_addr;
	logic [CH_W-1:0]  ch_val;
	assign ch_rd_addr = (state_q == S_EMIT) ? ch_ptr_q[CHI_W-1:0] : CARRIER_CH;
	assign ch_val     = ch_ok_q ? ch_rd_q : CH_RESET;

	// carrier-strength step on channel 12
	logic [CH_W-1:0] c12_next;
	always_comb begin
		c12_next = ch_val;
		if (carrier_q) begin
			if (ch_val < ceil_q)
				c12_next = ch_val + 11'd1;
		end else begin
			if (ch_val > floor_q)
				c12_next = ch_val - 11'd1;
		end
	end

	// ---------------------------------------------------------------
	// unpack: bytes stream LSB first into an accumulator, 11 bits come out
	logic        byte_issue;
	logic [17:0] ucomb;
	logic [4:0]  ucnt_sum;
	logic        u_extract;
	logic [17:0] uacc_d;
	logic [4:0]  ucnt_d;
	logic        unpack_done;

	assign byte_issue = (state_q == S_UNPACK) && (byte_ptr_q < PKT_IDX_W'(PKT_RD_BYTES));
	assign ucomb      = byte_vld_s1 ? (uacc_q | (18'(buf_rd_s1) << ucnt_q)) : uacc_q;
	assign ucnt_sum   = byte_vld_s1 ? (ucnt_q + 5'(BYTE_W)) : ucnt_q;
	assign u_extract  = (state_q == S_UNPACK) && (ucnt_sum >= 5'(CH_W))
		&& (uidx_q < CHI_W'(RADIO_CHANNELS));
	assign uacc_d     = u_extract ? (ucomb >> CH_W) : ucomb;
	assign ucnt_d     = u_extract ? (ucnt_sum - 5'(CH_W)) : ucnt_sum;
	assign unpack_done = (state_q == S_UNPACK) && !byte_issue && !byte_vld_s1
		&& !u_extract && !vld_s2 && !vld_s3 && !vld_s4;

	// map pipeline: s2 multiply by gain, s3 reciprocal of 1000, s4 correct
	logic signed [CH_W:0]      dif_s2;
	logic signed [PROD_W-1:0]  prd_s2;
	logic [MAG_W-1:0]          mag_s3;
	logic [2*MAG_W-1:0]        rcp_s3;
	logic [MAG_W-1:0]          rem_s4;
	logic [CH_W-1:0]           quo_s4;
	logic [CH_W-1:0]           map_s4;

	assign dif_s2 = $signed({1'b0, val_s2}) - $signed((CH_W+1)'(MAP_OFFSET));
	assign prd_s2 = $signed({{(PROD_W-CH_W-1){dif_s2[CH_W]}}, dif_s2})
		* $signed(PROD_W'(MAP_GAIN));
	assign mag_s3 = p_s3[PROD_W-1] ? MAG_W'(-p_s3) : MAG_W'(p_s3);
	assign rcp_s3 = (2*MAG_W)'(mag_s3) * (2*MAG_W)'(MAP_RECIP);
	assign rem_s4 = mag_s4 - MAG_W'({10'd0, q0_s4} * MAG_W'(MAP_DIV));
	assign quo_s4 = q0_s4 + CH_W'(rem_s4 >= MAG_W'(MAP_DIV));
	assign map_s4 = (neg_s4 ? (CH_W'(0) - quo_s4) : quo_s4) + CH_W'(MAP_BASE);

	// channel memory write port
	logic             ch_we;
	logic [CHI_W-1:0] ch_wa;
	logic [CH_W-1:0]  ch_wd;
	always_comb begin
		ch_we = 1'b0;
		ch_wa = CARRIER_CH;
		ch_wd = c12_next;
		if (state_q == S_C12) begin
			ch_we = 1'b1;
		end else if (vld_s4) begin
			ch_we = 1'b1;
			ch_wa = idx_s4;
			ch_wd = map_s4;
		end
	end

	// ---------------------------------------------------------------
	// emission: channels stream into an accumulator, bytes come out
	logic e_hdr, e_data, e_flag, e_ftr, e_load, emit_now;
	logic [BYTE_W-1:0] emit_byte;
	assign e_hdr  = (state_q == S_EMIT) && (ebyte_q == 5'd0);
	assign e_data = (state_q == S_EMIT) && (ebyte_q >= 5'(FIRST_DATA_IDX))
		&& (ebyte_q <= 5'(DATA_LAST_IDX));
	assign e_flag = (state_q == S_EMIT) && (ebyte_q == 5'(FLAG_IDX));
	assign e_ftr  = (state_q == S_EMIT) && (ebyte_q == 5'(LAST_IDX));
	assign e_load = e_data && (ecnt_q < 5'(BYTE_W)) && (ch_ptr_q < 5'(SBUS_CH));
	assign emit_now = out_free && (e_hdr || e_flag || e_ftr
		|| (e_data && (ecnt_q >= 5'(BYTE_W))));

	always_comb begin
		emit_byte = eacc_q[BYTE_W-1:0];
		if (e_hdr)
			emit_byte = FRAME_HDR;
		else if (e_flag)
			emit_byte = failsafe_q ? FLAG_FAILSAFE : FLAG_NONE;
		else if (e_ftr)
			emit_byte = FRAME_FTR;
	end

	// ---------------------------------------------------------------
	// memories
	always_ff @(posedge clk) begin
		if (in_acc && (action == ACT_BYTE) && (widx_q < PKT_IDX_W'(PKT_BYTES)))
			pkt_mem[widx_q] <= data_byte;
		buf_rd_s1 <= pkt_mem[byte_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (ch_we)
			chan_mem[ch_wa] <= ch_wd;
		ch_rd_q <= chan_mem[ch_rd_addr];
	end

	// map pipeline data
	always_ff @(posedge clk) begin
		val_s2 <= ucomb[CH_W-1:0];
		idx_s2 <= uidx_q;
		p_s3   <= prd_s2;
		idx_s3 <= idx_s2;
		mag_s4 <= mag_s3;
		q0_s4  <= rcp_s3[MAP_SHIFT+CH_W-1:MAP_SHIFT];
		neg_s4 <= p_s3[PROD_W-1];
		idx_s4 <= idx_s3;
	end

	// ---------------------------------------------------------------
	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			timeout_q    <= TIMEOUT_RESET;
			floor_q      <= FLOOR_RESET;
			ceil_q       <= CEIL_RESET;
			widx_q       <= '0;
			pend_q       <= 1'b0;
			ms_q         <= '0;
			failsafe_q   <= 1'b0;
			carrier_q    <= 1'b0;
			chan_vld_q   <= '0;
			ch_ok_q      <= 1'b0;
			byte_ptr_q   <= '0;
			byte_vld_s1  <= 1'b0;
			uacc_q       <= '0;
			ucnt_q       <= '0;
			uidx_q       <= '0;
			vld_s2       <= 1'b0;
			vld_s3       <= 1'b0;
			vld_s4       <= 1'b0;
			ebyte_q      <= '0;
			ch_ptr_q     <= '0;
			eacc_q       <= '0;
			ecnt_q       <= '0;
			out_valid_q  <= 1'b0;
			frame_byte_q <= '0;
			frame_last_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TIMEOUT: timeout_q <= cfg_data;
					REG_FLOOR:   floor_q   <= cfg_data;
					REG_CEILING: ceil_q    <= cfg_data;
					default: ;
				endcase
			end

			if (ch_we)
				chan_vld_q[ch_wa] <= 1'b1;
			ch_ok_q <= chan_vld_q[ch_rd_addr];

			// unpack pipeline control
			byte_vld_s1 <= byte_issue;
			if (byte_issue)
				byte_ptr_q <= byte_ptr_q + 5'd1;
			if (state_q == S_UNPACK) begin
				uacc_q <= uacc_d;
				ucnt_q <= ucnt_d;
			end
			if (u_extract)
				uidx_q <= uidx_q + 4'd1;
			vld_s2 <= u_extract;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;

			// emission datapath
			if (e_load) begin
				eacc_q   <= eacc_q | (18'(ch_val) << ecnt_q);
				ecnt_q   <= ecnt_q + 5'(CH_W);
				ch_ptr_q <= ch_ptr_q + 5'd1;
			end else if (emit_now && e_data) begin
				eacc_q <= eacc_q >> BYTE_W;
				ecnt_q <= ecnt_q - 5'(BYTE_W);
			end
			if (emit_now)
				ebyte_q <= ebyte_q + 5'd1;

			// output register
			if (emit_now) begin
				out_valid_q  <= 1'b1;
				frame_byte_q <= emit_byte;
				frame_last_q <= e_ftr;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (action)
							ACT_BYTE: begin
								if (last_byte) begin
									widx_q <= '0;
									pend_q <= 1'b1;
									ms_q   <= '0;
								end else if (widx_q < PKT_IDX_W'(PKT_BYTES)) begin
									widx_q <= widx_q + 5'd1;
								end
							end
							ACT_TICK: begin
								if (ms_q < MS_MAX)
									ms_q <= ms_q + 11'd1;
							end
							ACT_SERVICE: begin
								if (svc_fail) begin
									failsafe_q <= 1'b1;
									ebyte_q    <= '0;
									ch_ptr_q   <= '0;
									eacc_q     <= '0;
									ecnt_q     <= '0;
									state_q    <= S_EMIT;
								end else begin
									failsafe_q <= 1'b0;
									carrier_q  <= carrier_detected;
									state_q    <= S_C12;
								end
							end
							default: ;
						endcase
					end
				end
				S_C12: begin
					if (pend_q) begin
						pend_q     <= 1'b0;
						byte_ptr_q <= '0;
						uacc_q     <= '0;
						ucnt_q     <= '0;
						uidx_q     <= '0;
						state_q    <= S_UNPACK;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_UNPACK: begin
					if (unpack_done) begin
						ebyte_q  <= '0;
						ch_ptr_q <= '0;
						eacc_q   <= '0;
						ecnt_q   <= '0;
						state_q  <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_now && e_ftr)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = frame_byte_q;
	assign frame_last = frame_last_q;

	// ---------------------------------------------------------------
	// checks

	// all 16 channels consumed and the bit stream drained before the flags
	a_stream_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && ebyte_q == 5'(FLAG_IDX))
		|-> (ch_ptr_q == 5'(SBUS_CH) && ecnt_q == 5'd0))
		else $error("frame bit stream misaligned at flag byte");

	// every radio channel mapped before the frame starts
	a_unpack_count: assert property (@(posedge clk) disable iff (!arst_n)
		unpack_done |-> (uidx_q == CHI_W'(RADIO_CHANNELS)))
		else $error("unpack finished with wrong channel count");

	// no frame byte appears while the packet is being unpacked
	a_quiet_unpack: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UNPACK && !out_valid_q) |=> !out_valid_q)
		else $error("output during unpack");

	// map pipeline writes only while unpacking
	a_map_window: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> (state_q == S_UNPACK))
		else $error("channel map write outside unpack");

	// frame byte counter never runs past the footer
	a_ebyte_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (ebyte_q <= 5'(LAST_IDX)))
		else $error("frame byte counter overrun");

endmodule
